[rtl/sic_pkg.sv]
// shared constants and types for the segment intersection block
package sic_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int EPS_BITS           = 16;
   localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd7;
   localparam int QUEUE_DEPTH        = 4;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[rtl/sic_front.sv]
// front stage: takes a transaction, forms edge deltas and the common bounding box
module sic_front
   import sic_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int QW = 4 * (COORD_BITS + 1) + 8 * COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_d_x,
   input  logic signed [COORD_BITS-1:0] req_d_y,
   input  qstat_type                    qstat,
   output logic                         q_push,
   output logic [QW-1:0]                q_din
);

   localparam int W  = COORD_BITS;
   localparam int DF = W + 1;

   logic              f_valid_ff, f_valid_in;
   logic [QW-1:0]     f_data_ff, f_data_in;
   logic              req_accept;

   logic signed [DF-1:0] a2, b2, a1, b1;
   logic signed [W-1:0]  min_x1, max_x1, min_y1, max_y1;
   logic signed [W-1:0]  min_x2, max_x2, min_y2, max_y2;
   logic signed [W-1:0]  lo_x, hi_x, lo_y, hi_y;

   assign req_stall  = f_valid_ff && qstat.full;
   assign req_accept = req_valid && !req_stall;
   assign q_push     = f_valid_ff && !qstat.full;
   assign q_din      = f_data_ff;

   always_comb begin
      a2 = DF'(req_b_y) - DF'(req_a_y);
      b2 = DF'(req_a_x) - DF'(req_b_x);
      a1 = DF'(req_c_y) - DF'(req_d_y);
      b1 = DF'(req_d_x) - DF'(req_c_x);
      min_x1 = (req_a_x < req_b_x) ? req_a_x : req_b_x;
      max_x1 = (req_a_x < req_b_x) ? req_b_x : req_a_x;
      min_y1 = (req_a_y < req_b_y) ? req_a_y : req_b_y;
      max_y1 = (req_a_y < req_b_y) ? req_b_y : req_a_y;
      min_x2 = (req_c_x < req_d_x) ? req_c_x : req_d_x;
      max_x2 = (req_c_x < req_d_x) ? req_d_x : req_c_x;
      min_y2 = (req_c_y < req_d_y) ? req_c_y : req_d_y;
      max_y2 = (req_c_y < req_d_y) ? req_d_y : req_c_y;
      // intersection of both boxes, may be empty
      lo_x = (min_x1 > min_x2) ? min_x1 : min_x2;
      hi_x = (max_x1 < max_x2) ? max_x1 : max_x2;
      lo_y = (min_y1 > min_y2) ? min_y1 : min_y2;
      hi_y = (max_y1 < max_y2) ? max_y1 : max_y2;
      f_data_in = {a2, b2, a1, b1, req_a_x, req_a_y, req_d_x, req_d_y,
                   lo_x, hi_x, lo_y, hi_y};
      f_valid_in = req_accept || (f_valid_ff && qstat.full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         f_data_ff <= f_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_stall_only_when_holding: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> f_valid_ff && !q_push)
      else $error("front stalls without a held transaction");
`endif

endmodule

[rtl/sic_queue.sv]
// small fifo between front and back
module sic_queue
   import sic_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] din,
   input  logic              pop,
   output logic [DATA_W-1:0] dout,
   output qstat_type         qstat
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign qstat.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign dout        = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= din;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue pop while empty");
`endif

endmodule

[rtl/sic_back.sv]
// back pipeline: cramer numerators, determinant and box tests by cross multiply
module sic_back
   import sic_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int QW = 4 * (COORD_BITS + 1) + 8 * COORD_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [EPS_BITS-1:0] csr_wr_data,
   input  qstat_type           qstat,
   input  logic [QW-1:0]       q_dout,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit
);

   localparam int W      = COORD_BITS;
   localparam int DF     = W + 1;
   localparam int PD     = 2 * W + 2;
   localparam int CW     = 2 * W + 2;
   localparam int DW     = 2 * W + 3;
   localparam int SPL    = W + 1;
   localparam int XP     = 2 * W + 3;
   localparam int BP     = 2 * W + 2;
   localparam int RW     = 3 * W + 6;
   localparam int NSTAGE = 8;

   logic [EPS_BITS-1:0] det_epsilon_ff;
   logic [NSTAGE-1:0]   v_ff;
   logic                adv;

   logic signed [DF-1:0] u_a2, u_b2, u_a1, u_b1;
   logic signed [W-1:0]  u_ax, u_ay, u_dx, u_dy, u_lox, u_hix, u_loy, u_hiy;

   assign {u_a2, u_b2, u_a1, u_b1, u_ax, u_ay, u_dx, u_dy,
           u_lox, u_hix, u_loy, u_hiy} = q_dout;

   assign adv       = !v_ff[NSTAGE-1] || !rsp_stall;
   assign q_pop     = adv && !qstat.empty;
   assign rsp_valid = v_ff[NSTAGE-1];

   // stage 1: first products
   logic signed [PD-1:0] s1_a2ax_ff, s1_b2ay_ff, s1_a1dx_ff, s1_b1dy_ff;
   logic signed [PD-1:0] s1_a1b2_ff, s1_a2b1_ff;
   logic signed [DF-1:0] s1_a2_ff, s1_b2_ff, s1_a1_ff, s1_b1_ff;
   logic signed [W-1:0]  s1_lox_ff, s1_hix_ff, s1_loy_ff, s1_hiy_ff;

   // stage 2: line constants and determinant
   logic signed [CW-1:0] s2_c1_ff, s2_c2_ff;
   logic signed [DW-1:0] s2_det_ff;
   logic signed [DF-1:0] s2_a2_ff, s2_b2_ff, s2_a1_ff, s2_b1_ff;
   logic signed [W-1:0]  s2_lox_ff, s2_hix_ff, s2_loy_ff, s2_hiy_ff;

   // stage 3: split partial products, parallel test
   logic signed [XP-1:0] s3_xl_ff [4];
   logic signed [XP-1:0] s3_xh_ff [4];
   logic signed [BP-1:0] s3_bl_ff [4];
   logic signed [BP-1:0] s3_bh_ff [4];
   logic                 s3_ok_ff, s3_dneg_ff;
   logic [DW-1:0]        s3_mag_ff;

   logic signed [DF-1:0]    x_a [4];
   logic signed [CW-1:0]    x_c [4];
   logic signed [W-1:0]     bnd [4];
   logic signed [SPL:0]     det_lo;
   logic signed [DW-SPL-1:0] det_hi;
   logic [DW-1:0]           mag_in;

   // stage 4: recombined products
   logic signed [RW-1:0] s4_x_ff [4];
   logic signed [RW-1:0] s4_b_ff [4];
   logic                 s4_ok_ff, s4_dneg_ff;
   logic [DW-1:0]        s4_mag_ff;

   // stage 5: numerators
   logic signed [RW-1:0] s5_nx_ff, s5_ny_ff;
   logic signed [RW-1:0] s5_b_ff [4];
   logic                 s5_ok_ff, s5_dneg_ff;
   logic [DW-1:0]        s5_mag_ff;

   // stage 6: distance of numerator from bound times det
   logic signed [RW-1:0] s6_rlx_ff, s6_rhx_ff, s6_rly_ff, s6_rhy_ff;
   logic                 s6_nnx_ff, s6_nny_ff, s6_ok_ff, s6_dneg_ff;
   logic [DW-1:0]        s6_mag_ff;

   // stage 7: sign normalized to a positive det
   logic signed [RW-1:0] s7_rlx_ff, s7_rhx_ff, s7_rly_ff, s7_rhy_ff;
   logic                 s7_nnx_ff, s7_nny_ff, s7_ok_ff;
   logic signed [RW-1:0] s7_dm_ff;

   // stage 8 result
   logic                 rsp_hit_ff;
   logic signed [RW-1:0] t_rhx, t_rlx, t_rhy, t_rly;
   logic                 x_ok, y_ok;

   always_comb begin
      x_a[0] = s2_b2_ff; x_c[0] = s2_c1_ff;
      x_a[1] = s2_b1_ff; x_c[1] = s2_c2_ff;
      x_a[2] = s2_a1_ff; x_c[2] = s2_c2_ff;
      x_a[3] = s2_a2_ff; x_c[3] = s2_c1_ff;
      bnd[0] = s2_lox_ff; bnd[1] = s2_hix_ff;
      bnd[2] = s2_loy_ff; bnd[3] = s2_hiy_ff;
      det_lo = $signed({1'b0, s2_det_ff[SPL-1:0]});
      det_hi = $signed(s2_det_ff[DW-1:SPL]);
      mag_in = s2_det_ff[DW-1] ? $unsigned(-s2_det_ff) : $unsigned(s2_det_ff);
   end

   // conditions for trunc(n/d) inside [lo, hi] with d > 0
   always_comb begin
      t_rhx = s7_rhx_ff - s7_dm_ff;
      t_rlx = s7_rlx_ff + s7_dm_ff;
      t_rhy = s7_rhy_ff - s7_dm_ff;
      t_rly = s7_rly_ff + s7_dm_ff;
      x_ok = s7_nnx_ff ? (!s7_rlx_ff[RW-1] && t_rhx[RW-1])
                       : (!t_rlx[RW-1] && (t_rlx != '0) &&
                          (s7_rhx_ff[RW-1] || (s7_rhx_ff == '0)));
      y_ok = s7_nny_ff ? (!s7_rly_ff[RW-1] && t_rhy[RW-1])
                       : (!t_rly[RW-1] && (t_rly != '0) &&
                          (s7_rhy_ff[RW-1] || (s7_rhy_ff == '0)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff           <= '0;
         det_epsilon_ff <= EPS_RESET;
      end else begin
         if (adv) begin
            v_ff <= {v_ff[NSTAGE-2:0], q_pop};
         end
         if (csr_wr_en) begin
            det_epsilon_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a2ax_ff <= PD'(u_a2) * PD'(u_ax);
         s1_b2ay_ff <= PD'(u_b2) * PD'(u_ay);
         s1_a1dx_ff <= PD'(u_a1) * PD'(u_dx);
         s1_b1dy_ff <= PD'(u_b1) * PD'(u_dy);
         s1_a1b2_ff <= PD'(u_a1) * PD'(u_b2);
         s1_a2b1_ff <= PD'(u_a2) * PD'(u_b1);
         s1_a2_ff <= u_a2; s1_b2_ff <= u_b2; s1_a1_ff <= u_a1; s1_b1_ff <= u_b1;
         s1_lox_ff <= u_lox; s1_hix_ff <= u_hix;
         s1_loy_ff <= u_loy; s1_hiy_ff <= u_hiy;

         s2_c2_ff  <= CW'(s1_a2ax_ff) + CW'(s1_b2ay_ff);
         s2_c1_ff  <= CW'(s1_a1dx_ff) + CW'(s1_b1dy_ff);
         s2_det_ff <= DW'(s1_a1b2_ff) - DW'(s1_a2b1_ff);
         s2_a2_ff <= s1_a2_ff; s2_b2_ff <= s1_b2_ff;
         s2_a1_ff <= s1_a1_ff; s2_b1_ff <= s1_b1_ff;
         s2_lox_ff <= s1_lox_ff; s2_hix_ff <= s1_hix_ff;
         s2_loy_ff <= s1_loy_ff; s2_hiy_ff <= s1_hiy_ff;

         for (int i = 0; i < 4; i++) begin
            s3_xl_ff[i] <= XP'(x_a[i]) * XP'($signed({1'b0, x_c[i][SPL-1:0]}));
            s3_xh_ff[i] <= XP'(x_a[i]) * XP'($signed(x_c[i][CW-1:SPL]));
            s3_bl_ff[i] <= BP'(bnd[i]) * BP'(det_lo);
            s3_bh_ff[i] <= BP'(bnd[i]) * BP'(det_hi);
         end
         s3_ok_ff   <= (s2_det_ff != '0) && (mag_in >= DW'(det_epsilon_ff));
         s3_dneg_ff <= s2_det_ff[DW-1];
         s3_mag_ff  <= mag_in;

         for (int i = 0; i < 4; i++) begin
            s4_x_ff[i] <= (RW'(s3_xh_ff[i]) <<< SPL) + RW'(s3_xl_ff[i]);
            s4_b_ff[i] <= (RW'(s3_bh_ff[i]) <<< SPL) + RW'(s3_bl_ff[i]);
         end
         s4_ok_ff <= s3_ok_ff; s4_dneg_ff <= s3_dneg_ff; s4_mag_ff <= s3_mag_ff;

         s5_nx_ff <= s4_x_ff[0] - s4_x_ff[1];
         s5_ny_ff <= s4_x_ff[2] - s4_x_ff[3];
         for (int i = 0; i < 4; i++) begin
            s5_b_ff[i] <= s4_b_ff[i];
         end
         s5_ok_ff <= s4_ok_ff; s5_dneg_ff <= s4_dneg_ff; s5_mag_ff <= s4_mag_ff;

         s6_rlx_ff <= s5_nx_ff - s5_b_ff[0];
         s6_rhx_ff <= s5_nx_ff - s5_b_ff[1];
         s6_rly_ff <= s5_ny_ff - s5_b_ff[2];
         s6_rhy_ff <= s5_ny_ff - s5_b_ff[3];
         s6_nnx_ff <= (s5_nx_ff == '0) || (s5_nx_ff[RW-1] == s5_dneg_ff);
         s6_nny_ff <= (s5_ny_ff == '0) || (s5_ny_ff[RW-1] == s5_dneg_ff);
         s6_ok_ff <= s5_ok_ff; s6_dneg_ff <= s5_dneg_ff; s6_mag_ff <= s5_mag_ff;

         s7_rlx_ff <= s6_dneg_ff ? -s6_rlx_ff : s6_rlx_ff;
         s7_rhx_ff <= s6_dneg_ff ? -s6_rhx_ff : s6_rhx_ff;
         s7_rly_ff <= s6_dneg_ff ? -s6_rly_ff : s6_rly_ff;
         s7_rhy_ff <= s6_dneg_ff ? -s6_rhy_ff : s6_rhy_ff;
         s7_nnx_ff <= s6_nnx_ff; s7_nny_ff <= s6_nny_ff; s7_ok_ff <= s6_ok_ff;
         s7_dm_ff  <= RW'($signed({1'b0, s6_mag_ff}));

         rsp_hit_ff <= s7_ok_ff && x_ok && y_ok;
      end
   end

   assign rsp_hit = rsp_hit_ff;

`ifndef ASSERT_OFF
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff) && $stable(rsp_hit_ff))
      else $error("back pipeline moved while stalled");
`endif

endmodule

[rtl/segment_intersection_cramer_top.sv]
// Segment intersection by Cramer's rule on signed fixed-point endpoints.
// One transaction per clock is sustained while neither side stalls; a transaction's
// hit passes from the front register into the queue and then through 8 back stages.
// The back stages are fully pipelined multiply and add steps, the widest product
// being about COORD_BITS+2 bits square; the intersection point is never divided
// out, its truncated value is tested against the shared bounding box by cross
// multiplication with the determinant. A 4-entry queue separates the front from
// the back so either side may stall. det_epsilon is written through
// csr_wr_en/csr_wr_data, by the user only while idle; the block does not enforce it.
module segment_intersection_cramer_top
   import sic_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [EPS_BITS-1:0]          csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_d_x,
   input  logic signed [COORD_BITS-1:0] req_d_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit
);

   localparam int QW = 4 * (COORD_BITS + 1) + 8 * COORD_BITS;

   qstat_type     qstat;
   logic          q_push, q_pop;
   logic [QW-1:0] q_din, q_dout;

   sic_front #(.COORD_BITS(COORD_BITS), .QW(QW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_a_x   (req_a_x),
      .req_a_y   (req_a_y),
      .req_b_x   (req_b_x),
      .req_b_y   (req_b_y),
      .req_c_x   (req_c_x),
      .req_c_y   (req_c_y),
      .req_d_x   (req_d_x),
      .req_d_y   (req_d_y),
      .qstat     (qstat),
      .q_push    (q_push),
      .q_din     (q_din)
   );

   sic_queue #(.DATA_W(QW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .qstat (qstat)
   );

   sic_back #(.COORD_BITS(COORD_BITS), .QW(QW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .qstat       (qstat),
      .q_dout      (q_dout),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_hit     (rsp_hit)
   );

endmodule

[dv/tb.sv]
// testbench for the segment intersection block: directed table, random pairs, predictor check
module tb
   import sic_pkg::*;
();

   localparam int CB = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int WANT_PREDICT = 2;

   typedef struct packed {
      logic signed [CB-1:0] a_x;
      logic signed [CB-1:0] a_y;
      logic signed [CB-1:0] b_x;
      logic signed [CB-1:0] b_y;
      logic signed [CB-1:0] c_x;
      logic signed [CB-1:0] c_y;
      logic signed [CB-1:0] d_x;
      logic signed [CB-1:0] d_y;
   } seg_pair_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [EPS_BITS-1:0] csr_wr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   seg_pair_type pair = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_hit;

   segment_intersection_cramer_top dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(pair.a_x), .req_a_y(pair.a_y), .req_b_x(pair.b_x), .req_b_y(pair.b_y),
      .req_c_x(pair.c_x), .req_c_y(pair.c_y), .req_d_x(pair.d_x), .req_d_y(pair.d_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit)
   );

   always #5 clock = ~clock;

   logic [EPS_BITS-1:0] eps_model = EPS_RESET;
   bit hit_expected[$];
   seg_pair_type table_pairs[$];
   int table_want[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int mismatches = 0;
   int hits_seen = 0;
   int results_seen = 0;
   int cycles = 0;

   function automatic bit hit_of(seg_pair_type s, logic [EPS_BITS-1:0] eps);
      logic signed [127:0] ax, ay, bx, by, cx, cy, dx, dy;
      logic signed [127:0] a1, b1, a2, b2, c1, c2, det, mag, px, py;
      ax = s.a_x; ay = s.a_y; bx = s.b_x; by = s.b_y;
      cx = s.c_x; cy = s.c_y; dx = s.d_x; dy = s.d_y;
      a2 = by - ay; b2 = ax - bx;
      a1 = cy - dy; b1 = dx - cx;
      c2 = a2 * ax + b2 * ay;
      c1 = a1 * dx + b1 * dy;
      det = a1 * b2 - a2 * b1;
      mag = (det < 0) ? -det : det;
      if (mag == 0 || mag < $signed({112'd0, eps})) return 1'b0;
      // signed division truncates toward zero
      px = (b2 * c1 - b1 * c2) / det;
      py = (a1 * c2 - a2 * c1) / det;
      if (px < ((ax < bx) ? ax : bx) || px > ((ax < bx) ? bx : ax)) return 1'b0;
      if (py < ((ay < by) ? ay : by) || py > ((ay < by) ? by : ay)) return 1'b0;
      if (px < ((cx < dx) ? cx : dx) || px > ((cx < dx) ? dx : cx)) return 1'b0;
      if (py < ((cy < dy) ? cy : dy) || py > ((cy < dy) ? dy : cy)) return 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // result side checking
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (hit_expected.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            if (rsp_hit !== hit_expected[0])
               report_mismatch($sformatf("hit %b, expected %b", rsp_hit, hit_expected[0]));
            if (rsp_hit === 1'b1) hits_seen <= hits_seen + 1;
            void'(hit_expected.pop_front());
         end
      end
   end

   // result side stall pattern and long hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycles);
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send_pair(input seg_pair_type s, input int want);
      bit predicted;
      pair <= s;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      predicted = hit_of(s, eps_model);
      if (want != WANT_PREDICT && predicted != want[0])
         report_mismatch($sformatf("table row expects %0d, predictor %0d", want, predicted));
      hit_expected.push_back(predicted);
      // each cycle idle with the given chance
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (hit_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_eps(input logic [EPS_BITS-1:0] v);
      wait_idle();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      eps_model = v;
   endtask

   function automatic seg_pair_type mk(input int ax, ay, bx, by, cx, cy, dx, dy);
      seg_pair_type s;
      s.a_x = CB'(ax); s.a_y = CB'(ay); s.b_x = CB'(bx); s.b_y = CB'(by);
      s.c_x = CB'(cx); s.c_y = CB'(cy); s.d_x = CB'(dx); s.d_y = CB'(dy);
      return s;
   endfunction

   function automatic int rc(input int span);
      return int'($urandom_range(2 * span, 0)) - span;
   endfunction

   function automatic seg_pair_type random_pair();
      seg_pair_type s;
      int kind, k;
      kind = $urandom_range(99, 0);
      if (kind < 55) begin
         // random pair with small coordinates
         s = mk(rc(2048), rc(2048), rc(2048), rc(2048), rc(2048), rc(2048), rc(2048), rc(2048));
      end else if (kind < 75) begin
         s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (kind < 85) begin
         // nearly parallel: CD is AB shifted and nudged
         s = mk(rc(4096), rc(4096), rc(4096), rc(4096), 0, 0, 0, 0);
         k = rc(64);
         s.c_x = CB'(s.a_x + k); s.c_y = CB'(s.a_y - k);
         s.d_x = CB'(s.b_x + k + rc(2)); s.d_y = CB'(s.b_y - k + rc(2));
      end else if (kind < 93) begin
         // shared endpoint
         s = mk(rc(1024), rc(1024), rc(1024), rc(1024), 0, 0, rc(1024), rc(1024));
         s.c_x = s.b_x; s.c_y = s.b_y;
      end else begin
         // degenerate segment
         s = mk(rc(1024), rc(1024), 0, 0, rc(1024), rc(1024), rc(1024), rc(1024));
         s.b_x = s.a_x; s.b_y = s.a_y;
      end
      return s;
   endfunction

   task automatic random_phase(input int n, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (n) send_pair(random_pair(), WANT_PREDICT);
   endtask

   localparam int MAXC = 8388607;
   localparam int MINC = -8388608;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed table, det_epsilon at its reset value
      table_pairs.push_back(mk(-256, -256, 256, 256, -256, 256, 256, -256)); table_want.push_back(1);
      table_pairs.push_back(mk(0, 0, 256, 0, 0, 256, 256, 256));       table_want.push_back(0);
      table_pairs.push_back(mk(0, 0, 512, 0, 256, 0, 768, 0));         table_want.push_back(0);
      table_pairs.push_back(mk(5, 5, 5, 5, -256, 0, 256, 0));          table_want.push_back(0);
      table_pairs.push_back(mk(0, 0, 256, 0, 512, -256, 512, 256));    table_want.push_back(0);
      table_pairs.push_back(mk(0, 0, 256, 256, 256, 256, 512, 0));     table_want.push_back(1);
      table_pairs.push_back(mk(0, 0, 1, 0, 0, -1, 0, 1));              table_want.push_back(0);
      table_pairs.push_back(mk(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC));
      table_want.push_back(WANT_PREDICT);
      table_pairs.push_back(mk(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC));
      table_want.push_back(WANT_PREDICT);
      table_pairs.push_back(mk(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC));   table_want.push_back(1);
      table_pairs.push_back(mk(MAXC, MAXC, MAXC, MAXC, 0, 0, 1, 1));   table_want.push_back(0);
      table_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));       table_want.push_back(0);
      // truncation near box edges
      table_pairs.push_back(mk(0, 0, 3, 1, 0, 1, 3, 0));               table_want.push_back(WANT_PREDICT);
      table_pairs.push_back(mk(-3, -1, 0, 0, -3, 0, 0, -1));           table_want.push_back(WANT_PREDICT);
      table_pairs.push_back(mk(0, 0, 7, 3, 1, 3, 6, -2));              table_want.push_back(WANT_PREDICT);
      send_idle_pct = 11;
      recv_idle_pct = 55;
      foreach (table_pairs[i]) send_pair(table_pairs[i], table_want[i]);

      write_eps(16'd0);
      send_pair(mk(0, 0, 1, 0, 0, -1, 0, 1), WANT_PREDICT);
      send_pair(mk(0, 0, 256, 0, 0, 256, 256, 256), 0);
      random_phase(280, 11, 55);

      write_eps(16'hFFFF);
      random_phase(220, 55, 11);

      write_eps(EPS_BITS'($urandom_range(200, 1)));
      random_phase(220, 0, 0);

      // long receiver hold-off while the sender keeps offering
      write_eps(16'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_cycles = 300;
      repeat (60) send_pair(random_pair(), WANT_PREDICT);
      // sender pauses until everything has drained
      req_valid <= 0;
      while (hit_expected.size() != 0) @(posedge clock);
      random_phase(150, 30, 30);

      wait_idle();
      $display("tb: %0d results checked, %0d hits, det_epsilon swept over 7, 0, 65535, random, 1",
               results_seen, hits_seen);
      $display("tb: covered stalls on both sides and a long result hold-off");
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
